// ===== hdl/knn_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the k-nearest-neighbor classifier.
// Used by knn_cell and knn_classifier; depends on nothing else.
package knn_pkg;

   // field and register widths
   localparam int PIXEL_W       = 8;
   localparam int LABEL_W       = 4;
   localparam int DIST_W        = 27;
   localparam int OUT_DIST_W    = 26;
   localparam int VOTES_W       = 4;
   localparam int NEIGHBOR_W    = 4;
   localparam int PIXEL_COUNT_W = 11;
   localparam int CSR_DATA_W    = 11;
   localparam int CSR_INDEX_W   = 1;
   localparam int SQUARE_W      = 2 * PIXEL_W;

   // register indexes and reset values
   localparam logic [CSR_INDEX_W-1:0]   CSR_NEIGHBOR_COUNT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0]   CSR_PIXEL_COUNT    = 1'd1;
   localparam logic [NEIGHBOR_W-1:0]    NEIGHBOR_RESET     = 4'd3;
   localparam logic [PIXEL_COUNT_W-1:0] PIXEL_COUNT_RESET  = 11'd784;

   // input commands
   localparam logic CMD_QUERY = 1'b0;
   localparam logic CMD_TRAIN = 1'b1;

   // control from the sequencer to every cell of the sorted list
   typedef struct packed {
      logic               insert;
      logic               clear;
      logic [DIST_W-1:0]  distance;
      logic [LABEL_W-1:0] label;
      logic [LABEL_W-1:0] vote_class;
   } knn_ctl_type;

   // what one cell hands to its right neighbor
   typedef struct packed {
      logic               keep;
      logic               valid;
      logic [DIST_W-1:0]  distance;
      logic [LABEL_W-1:0] label;
   } knn_link_type;

endpackage

// ===== hdl/knn_cell.sv =====
`timescale 1ns / 1ps
// One entry of the sorted nearest-neighbor list: distance, label and valid.
// Depends on knn_pkg for the control and link types.
module knn_cell
   import knn_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  knn_ctl_type  ctl,
   input  knn_link_type left,
   input  logic         vote_en,
   output knn_link_type right,
   output logic         vote
);

   logic               valid_ff, valid_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic [LABEL_W-1:0] label_ff, label_in;
   logic               keep;

   // an entry no farther than the new sample stays; earlier samples win ties
   assign keep = valid_ff && (dist_ff <= ctl.distance);

   // clear the entry, stay, take the new sample, or shift in the left neighbor
   always_comb begin
      valid_in = valid_ff;
      dist_in  = dist_ff;
      label_in = label_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.insert && !keep) begin
         valid_in = valid_ff | left.valid;
         if (left.keep) begin
            dist_in  = ctl.distance;
            label_in = ctl.label;
         end else begin
            dist_in  = left.distance;
            label_in = left.label;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      dist_ff  <= dist_in;
      label_ff <= label_in;
   end

   assign right.keep     = keep;
   assign right.valid    = valid_ff;
   assign right.distance = dist_ff;
   assign right.label    = label_ff;

   // this entry votes for the class under test
   assign vote = vote_en && valid_ff && (label_ff == ctl.vote_class);

endmodule

// ===== hdl/knn_classifier.sv =====
`timescale 1ns / 1ps
// Top level of the k-nearest-neighbor classifier: query store, distance
// sequencer, chain of list cells and majority vote. Uses knn_pkg and knn_cell.
//
//   channel | ports                                         | direction
//   req     | req_valid req_stall req_cmd req_pixel         | in (stall out)
//           | req_label req_end_of_set                      |
//   rsp     | rsp_valid rsp_stall rsp_predicted_class       | out (stall in)
//           | rsp_winning_votes rsp_nearest_distance        |
//   csr     | csr_write csr_index csr_data                  | in
//
// A query pixel is taken while idle; a training pixel is squared and then
// accumulated, and the last pixel of a training image is also inserted into
// the cell chain. After the final pixel of a set, the vote walks one class
// per cycle. reset is synchronous; it clears the position, distance and list,
// not the query store. A waiting result in the output register holds back
// the next delivery and the requests after it, never the pixel work before it.
module knn_classifier
   import knn_pkg::*;
#(
   parameter int PIXEL_SLOTS = 1024,
   parameter int K_MAX       = 8,
   parameter int CLASSES     = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_cmd,
   input  logic [PIXEL_W-1:0]       req_pixel,
   input  logic [LABEL_W-1:0]       req_label,
   input  logic                     req_end_of_set,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [LABEL_W-1:0]       rsp_predicted_class,
   output logic [VOTES_W-1:0]       rsp_winning_votes,
   output logic [OUT_DIST_W-1:0]    rsp_nearest_distance,
   input  logic                     csr_write,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   localparam int POS_W  = (PIXEL_SLOTS > 1) ? $clog2(PIXEL_SLOTS) : 1;
   localparam int SLOT_W = $clog2(PIXEL_SLOTS + 1);
   localparam int CNT_W  = (SLOT_W > PIXEL_COUNT_W) ? SLOT_W : PIXEL_COUNT_W;
   localparam int KCNT_W = $clog2(K_MAX + 1);
   localparam int KN_W   = (KCNT_W > NEIGHBOR_W) ? KCNT_W : NEIGHBOR_W;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SQUARE  = 3'd1;
   localparam logic [2:0] ST_ACCUM   = 3'd2;
   localparam logic [2:0] ST_INSERT  = 3'd3;
   localparam logic [2:0] ST_VOTE    = 3'd4;
   localparam logic [2:0] ST_DELIVER = 3'd5;

   // configuration registers
   logic [NEIGHBOR_W-1:0]    neighbor_ff;
   logic [PIXEL_COUNT_W-1:0] pixel_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         neighbor_ff    <= NEIGHBOR_RESET;
         pixel_count_ff <= PIXEL_COUNT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_NEIGHBOR_COUNT: neighbor_ff    <= csr_data[NEIGHBOR_W-1:0];
            CSR_PIXEL_COUNT:    pixel_count_ff <= csr_data[PIXEL_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer state
   logic [2:0]          state_ff, state_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [DIST_W-1:0]   run_ff, run_in;
   logic [PIXEL_W-1:0]  pix_ff;
   logic [LABEL_W-1:0]  label_ff;
   logic                eos_ff, last_ff;
   logic [PIXEL_W-1:0]  query_ff;
   logic [SQUARE_W-1:0] sq_ff;
   logic [LABEL_W-1:0]  class_ff, class_in;
   logic [LABEL_W-1:0]  best_class_ff, best_class_in;
   logic [KCNT_W-1:0]   best_votes_ff, best_votes_in;

   logic                accept, last_now, load_rsp;
   logic [CNT_W-1:0]    eff_count, pos_ext, pos_next;
   logic [POS_W-1:0]    pos_idx;
   logic [PIXEL_W-1:0]  diff;
   logic [LABEL_W-1:0]  label_clamped;
   logic [KN_W-1:0]     eff_k;
   logic [KCNT_W-1:0]   votes_now;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // clamp the pixel count and wrap a position beyond the store
   always_comb begin
      eff_count = CNT_W'(pixel_count_ff);
      if (eff_count == '0) begin
         eff_count = CNT_W'(1);
      end else if (eff_count > CNT_W'(PIXEL_SLOTS)) begin
         eff_count = CNT_W'(PIXEL_SLOTS);
      end
      pos_ext = CNT_W'(pos_ff);
      if (pos_ext >= CNT_W'(PIXEL_SLOTS)) begin
         pos_ext = '0;
      end
      pos_idx  = pos_ext[POS_W-1:0];
      pos_next = pos_ext + CNT_W'(1);
      last_now = (pos_next >= eff_count);
   end

   assign label_clamped = ({1'b0, req_label} >= (LABEL_W + 1)'(CLASSES)) ?
                          LABEL_W'(CLASSES - 1) : req_label;

   // query store: written by query beats, read for training beats
   logic [PIXEL_W-1:0] query_mem [PIXEL_SLOTS];

   always_ff @(posedge clock) begin
      if (accept && (req_cmd == CMD_QUERY)) begin
         query_mem[pos_idx] <= req_pixel;
      end
      if (accept) begin
         query_ff <= query_mem[pos_idx];
      end
   end

   // capture the beat
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff   <= req_pixel;
         label_ff <= label_clamped;
         eos_ff   <= req_end_of_set;
         last_ff  <= last_now;
      end
   end

   // square the pixel difference
   assign diff = (pix_ff >= query_ff) ? (pix_ff - query_ff) : (query_ff - pix_ff);

   always_ff @(posedge clock) begin
      if (state_ff == ST_SQUARE) begin
         sq_ff <= SQUARE_W'(diff) * SQUARE_W'(diff);
      end
   end

   // cell chain
   knn_ctl_type  ctl;
   knn_link_type links [K_MAX];
   knn_link_type boundary;
   logic [K_MAX-1:0] vote_en, vote_bits;

   assign boundary.keep     = 1'b1;
   assign boundary.valid    = 1'b1;
   assign boundary.distance = '0;
   assign boundary.label    = '0;

   always_comb begin
      eff_k = KN_W'(neighbor_ff);
      if (eff_k == '0) begin
         eff_k = KN_W'(1);
      end else if (eff_k > KN_W'(K_MAX)) begin
         eff_k = KN_W'(K_MAX);
      end
   end

   for (genvar i = 0; i < K_MAX; i++) begin : g_cell
      assign vote_en[i] = (KN_W'(i) < eff_k);
      if (i == 0) begin : g_head
         knn_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctl     (ctl),
            .left    (boundary),
            .vote_en (vote_en[i]),
            .right   (links[i]),
            .vote    (vote_bits[i])
         );
      end else begin : g_body
         knn_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctl     (ctl),
            .left    (links[i-1]),
            .vote_en (vote_en[i]),
            .right   (links[i]),
            .vote    (vote_bits[i])
         );
      end
   end

   // count votes for the class under test
   always_comb begin
      votes_now = '0;
      for (int i = 0; i < K_MAX; i++) begin
         votes_now = votes_now + KCNT_W'(vote_bits[i]);
      end
   end

   assign load_rsp = (state_ff == ST_DELIVER) && (!rsp_valid || !rsp_stall);

   // advance the sequencer
   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      run_in         = run_ff;
      class_in       = class_ff;
      best_class_in  = best_class_ff;
      best_votes_in  = best_votes_ff;
      ctl.insert     = 1'b0;
      ctl.clear      = 1'b0;
      ctl.distance   = run_ff;
      ctl.label      = label_ff;
      ctl.vote_class = class_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pos_in = last_now ? '0 : pos_next[POS_W-1:0];
               if (req_cmd == CMD_TRAIN) begin
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            run_in   = run_ff + DIST_W'(sq_ff);
            state_in = last_ff ? ST_INSERT : ST_IDLE;
         end
         ST_INSERT: begin
            ctl.insert    = 1'b1;
            run_in        = '0;
            class_in      = '0;
            best_class_in = '0;
            best_votes_in = '0;
            state_in      = eos_ff ? ST_VOTE : ST_IDLE;
         end
         ST_VOTE: begin
            if (votes_now > best_votes_ff) begin
               best_votes_in = votes_now;
               best_class_in = class_ff;
            end
            class_in = class_ff + LABEL_W'(1);
            if (class_ff == LABEL_W'(CLASSES - 1)) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (load_rsp) begin
               ctl.clear = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         run_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         run_ff   <= run_in;
      end
      class_ff      <= class_in;
      best_class_ff <= best_class_in;
      best_votes_ff <= best_votes_in;
   end

   // output register: hold the beat until it is taken
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LABEL_W-1:0]    rsp_class_ff;
   logic [VOTES_W-1:0]    rsp_votes_ff;
   logic [OUT_DIST_W-1:0] rsp_dist_ff;

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load_rsp) begin
         rsp_class_ff <= best_class_ff;
         rsp_votes_ff <= VOTES_W'(best_votes_ff);
         rsp_dist_ff  <= links[0].distance[OUT_DIST_W-1:0];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_predicted_class  = rsp_class_ff;
   assign rsp_winning_votes    = rsp_votes_ff;
   assign rsp_nearest_distance = rsp_dist_ff;

endmodule
